// ===== src/bsle_pkg.sv =====
// Shared types and constants for the bounded sequence list engine.
// Depends on nothing; every other file in src refers to it by scoped names.
package bsle_pkg;

  // Default list geometry, handed down from the top level.
  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int CMD_W   = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  // Wide enough to compare a position against any element count.
  localparam int CMP_W   = 8;

  // Queue depths between the parts of the engine.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // Command codes on the request port.
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

  // Status codes on the result port.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // Operation class assigned by the front end.
  typedef enum logic [2:0] {
    OP_INS_BEFORE,
    OP_INS_AFTER,
    OP_DELETE,
    OP_LOCATE,
    OP_REVERSE,
    OP_DUMP,
    OP_BAD
  } op_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL_RD,
    ST_DEL_CAP,
    ST_DEL_SH,
    ST_LOC,
    ST_REV_A,
    ST_REV_B,
    ST_REV_C,
    ST_REV_D,
    ST_DUMP,
    ST_RESP
  } state_t;

  // Classified request passed from front to back.
  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;
  } cmd_t;

  // One result waiting for the receiver.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   result_value;
    logic [POS_W-1:0]   found_position;
    logic [COUNT_W-1:0] element_count;
    logic               last;
  } res_t;

endpackage

// ===== src/bsle_front.sv =====
// Front end of the list engine: accepts requests, classifies the command code
// and holds them in a short queue for the back end. Depends on bsle_pkg.
module bsle_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [bsle_pkg::CMD_W-1:0]    command,
  input  logic [bsle_pkg::POS_W-1:0]    position,
  input  logic [bsle_pkg::VAL_W-1:0]    item_value,
  output bsle_pkg::cmd_t                cmd,
  output logic                          cmd_valid,
  input  logic                          cmd_pop
);

  localparam logic [bsle_pkg::CQ_AW:0] FULL_CNT =
    bsle_pkg::CQ_DEPTH[bsle_pkg::CQ_AW:0];

  bsle_pkg::cmd_t               q [bsle_pkg::CQ_DEPTH];
  bsle_pkg::cmd_t               in_cmd;
  logic [bsle_pkg::CQ_AW-1:0]   wr_ptr;
  logic [bsle_pkg::CQ_AW-1:0]   rd_ptr;
  logic [bsle_pkg::CQ_AW:0]     fill;
  logic                         do_push;
  logic                         do_pop;

  // Classify the incoming command code.
  always_comb begin
    in_cmd.position   = position;
    in_cmd.item_value = item_value;
    unique case (command)
      bsle_pkg::CMD_INS_BEFORE: in_cmd.op = bsle_pkg::OP_INS_BEFORE;
      bsle_pkg::CMD_INS_AFTER:  in_cmd.op = bsle_pkg::OP_INS_AFTER;
      bsle_pkg::CMD_DELETE:     in_cmd.op = bsle_pkg::OP_DELETE;
      bsle_pkg::CMD_LOCATE:     in_cmd.op = bsle_pkg::OP_LOCATE;
      bsle_pkg::CMD_REVERSE:    in_cmd.op = bsle_pkg::OP_REVERSE;
      bsle_pkg::CMD_DUMP:       in_cmd.op = bsle_pkg::OP_DUMP;
      default:                  in_cmd.op = bsle_pkg::OP_BAD;
    endcase
  end

  // Queue handshake on both sides.
  assign full      = (fill == FULL_CNT);
  assign cmd_valid = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= in_cmd;
  end

endmodule

// ===== src/bsle_rq.sv =====
// Result queue of the list engine: buffers results until the receiver pops
// them and reports the free space to the back end. Depends on bsle_pkg.
module bsle_rq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_en,
  input  bsle_pkg::res_t             push_data,
  output logic [bsle_pkg::RQ_AW:0]   free,
  output logic                       empty,
  input  logic                       pop,
  output bsle_pkg::res_t             head
);

  localparam logic [bsle_pkg::RQ_AW:0] DEPTH_CNT =
    bsle_pkg::RQ_DEPTH[bsle_pkg::RQ_AW:0];

  bsle_pkg::res_t               q [bsle_pkg::RQ_DEPTH];
  logic [bsle_pkg::RQ_AW-1:0]   wr_ptr;
  logic [bsle_pkg::RQ_AW-1:0]   rd_ptr;
  logic [bsle_pkg::RQ_AW:0]     fill;
  logic                         do_pop;

  assign empty  = (fill == '0);
  assign free   = DEPTH_CNT - fill;
  assign do_pop = pop && !empty;
  assign head   = q[rd_ptr];

  // Pointers and fill level; the back end only pushes when space is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push_en && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_en) q[wr_ptr] <= push_data;
  end

endmodule

// ===== src/bsle_back.sv =====
// Back end of the list engine: the element memory, the element count and the
// sequencer that walks the memory for each command. Depends on bsle_pkg.
module bsle_back #(
  parameter int CAPACITY   = bsle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bsle_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsle_pkg::cmd_t             cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  logic [bsle_pkg::RQ_AW:0]   rq_free,
  output logic                       rq_push,
  output bsle_pkg::res_t             rq_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [bsle_pkg::RQ_AW:0] TWO_FREE = (bsle_pkg::RQ_AW + 1)'(2);

  // Element memory, one write and one registered read per cycle.
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [AW-1:0]         mem_ra;
  logic [DATA_WIDTH-1:0] rd_data;

  bsle_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             pend, pend_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    hi, hi_next;
  logic [CW-1:0]    idx, idx_next;
  logic [DATA_WIDTH-1:0] cur, cur_next;
  logic [DATA_WIDTH-1:0] tmp, tmp_next;
  logic [bsle_pkg::STAT_W-1:0] res_status, res_status_next;
  logic [bsle_pkg::VAL_W-1:0]  res_value, res_value_next;
  logic [bsle_pkg::POS_W-1:0]  res_found, res_found_next;

  logic [DATA_WIDTH-1:0]         in_st;
  logic [bsle_pkg::VAL_W-1:0]    rd_ext;
  logic [bsle_pkg::CMP_W-1:0]    pos_x;
  logic [bsle_pkg::CMP_W-1:0]    cnt_x;
  logic [CW-1:0]                 pos_c;
  logic                          is_full;

  // Request value to stored width, and stored word back to 32 bits, both
  // with sign extension.
  always_comb begin
    for (int i = 0; i < DATA_WIDTH; i++) begin
      in_st[i] = cmd.item_value[(i < bsle_pkg::VAL_W) ? i : bsle_pkg::VAL_W - 1];
    end
    for (int j = 0; j < bsle_pkg::VAL_W; j++) begin
      rd_ext[j] = rd_data[(j < DATA_WIDTH) ? j : DATA_WIDTH - 1];
    end
  end

  assign pos_x   = bsle_pkg::CMP_W'(cmd.position);
  assign cnt_x   = bsle_pkg::CMP_W'(count);
  assign pos_c   = CW'(cmd.position);
  assign is_full = (count >= CAP_CNT);

  // Memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsle_pkg::ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    hi         <= hi_next;
    idx        <= idx_next;
    cur        <= cur_next;
    tmp        <= tmp_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_found  <= res_found_next;
  end

  // Sequencer: next state, memory control and result pushes.
  always_comb begin
    state_next      = state;
    count_next      = count;
    pend_next       = pend;
    ptr_next        = ptr;
    hi_next         = hi;
    idx_next        = idx;
    cur_next        = cur;
    tmp_next        = tmp;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_found_next  = res_found;
    mem_we          = 1'b0;
    mem_wa          = ptr[AW-1:0];
    mem_wd          = rd_data;
    mem_ra          = ptr[AW-1:0];
    cmd_pop         = 1'b0;
    rq_push         = 1'b0;
    rq_data.status         = res_status;
    rq_data.result_value   = res_value;
    rq_data.found_position = res_found;
    rq_data.element_count  = bsle_pkg::COUNT_W'(count);
    rq_data.last           = 1'b1;

    unique case (state)
      bsle_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop         = 1'b1;
          cur_next        = in_st;
          ptr_next        = '0;
          pend_next       = 1'b0;
          res_status_next = bsle_pkg::STAT_OK;
          res_value_next  = '0;
          res_found_next  = '0;
          state_next      = bsle_pkg::ST_RESP;
          unique case (cmd.op)
            bsle_pkg::OP_INS_BEFORE: begin
              if (!(pos_x == '0 || pos_x < cnt_x)) begin
                res_status_next = bsle_pkg::STAT_BAD_POS;
              end else if (is_full) begin
                res_status_next = bsle_pkg::STAT_FULL;
              end else begin
                idx_next   = pos_c;
                ptr_next   = count;
                state_next = bsle_pkg::ST_INS;
              end
            end
            bsle_pkg::OP_INS_AFTER: begin
              if (count == '0 && pos_x == '0) begin
                idx_next = '0;
              end else begin
                idx_next = pos_c + 1'b1;
              end
              if (!((count == '0 && pos_x == '0) || pos_x < cnt_x)) begin
                res_status_next = bsle_pkg::STAT_BAD_POS;
              end else if (is_full) begin
                res_status_next = bsle_pkg::STAT_FULL;
              end else begin
                ptr_next   = count;
                state_next = bsle_pkg::ST_INS;
              end
            end
            bsle_pkg::OP_DELETE: begin
              if (pos_x >= cnt_x) begin
                res_status_next = bsle_pkg::STAT_BAD_POS;
              end else begin
                ptr_next   = pos_c;
                state_next = bsle_pkg::ST_DEL_RD;
              end
            end
            bsle_pkg::OP_LOCATE: begin
              state_next = bsle_pkg::ST_LOC;
            end
            bsle_pkg::OP_REVERSE: begin
              if (count > CW'(1)) begin
                hi_next    = count - 1'b1;
                state_next = bsle_pkg::ST_REV_A;
              end
            end
            bsle_pkg::OP_DUMP: begin
              if (count == '0) begin
                res_status_next = bsle_pkg::STAT_BAD_POS;
              end else begin
                state_next = bsle_pkg::ST_DUMP;
              end
            end
            default: begin
              res_status_next = bsle_pkg::STAT_BAD_POS;
            end
          endcase
        end
      end

      // Shift the tail up by one, top down, then drop the new value in.
      bsle_pkg::ST_INS: begin
        if (pend) begin
          mem_we = 1'b1;
          mem_wa = AW'(ptr + 1'b1);
          mem_wd = rd_data;
        end
        if (ptr > idx) begin
          mem_ra    = AW'(ptr - 1'b1);
          ptr_next  = ptr - 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            mem_we     = 1'b1;
            mem_wa     = idx[AW-1:0];
            mem_wd     = cur;
            count_next = count + 1'b1;
            state_next = bsle_pkg::ST_RESP;
          end
        end
      end

      // Read the element being removed.
      bsle_pkg::ST_DEL_RD: begin
        ptr_next   = ptr + 1'b1;
        state_next = bsle_pkg::ST_DEL_CAP;
      end

      bsle_pkg::ST_DEL_CAP: begin
        res_value_next = rd_ext;
        pend_next      = 1'b0;
        state_next     = bsle_pkg::ST_DEL_SH;
      end

      // Shift the tail down by one, bottom up.
      bsle_pkg::ST_DEL_SH: begin
        if (pend) begin
          mem_we = 1'b1;
          mem_wa = AW'(ptr - CW'(2));
          mem_wd = rd_data;
        end
        if (ptr < count) begin
          ptr_next  = ptr + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - 1'b1;
            state_next = bsle_pkg::ST_RESP;
          end
        end
      end

      // Scan from the front; each compare uses the word read in the cycle before.
      bsle_pkg::ST_LOC: begin
        if (pend && rd_data == cur) begin
          res_found_next = bsle_pkg::POS_W'(ptr - 1'b1);
          pend_next      = 1'b0;
          state_next     = bsle_pkg::ST_RESP;
        end else if (ptr < count) begin
          ptr_next  = ptr + 1'b1;
          pend_next = 1'b1;
        end else begin
          res_status_next = bsle_pkg::STAT_NOT_FOUND;
          pend_next       = 1'b0;
          state_next      = bsle_pkg::ST_RESP;
        end
      end

      // Swap the outer pair, then move both ends inward.
      bsle_pkg::ST_REV_A: begin
        if (ptr < hi) begin
          state_next = bsle_pkg::ST_REV_B;
        end else begin
          state_next = bsle_pkg::ST_RESP;
        end
      end

      bsle_pkg::ST_REV_B: begin
        mem_ra     = hi[AW-1:0];
        tmp_next   = rd_data;
        state_next = bsle_pkg::ST_REV_C;
      end

      bsle_pkg::ST_REV_C: begin
        mem_we     = 1'b1;
        mem_wa     = ptr[AW-1:0];
        mem_wd     = rd_data;
        state_next = bsle_pkg::ST_REV_D;
      end

      bsle_pkg::ST_REV_D: begin
        mem_we     = 1'b1;
        mem_wa     = hi[AW-1:0];
        mem_wd     = tmp;
        ptr_next   = ptr + 1'b1;
        hi_next    = hi - 1'b1;
        state_next = bsle_pkg::ST_REV_A;
      end

      // Stream every element; a read is issued only when two result slots
      // are free, so the trailing push always has room.
      bsle_pkg::ST_DUMP: begin
        if (pend) begin
          rq_push              = 1'b1;
          rq_data.status       = bsle_pkg::STAT_OK;
          rq_data.result_value = rd_ext;
          rq_data.found_position = '0;
          rq_data.last         = (ptr == count);
        end
        if (ptr < count && rq_free >= TWO_FREE) begin
          ptr_next  = ptr + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (ptr >= count) begin
            state_next = bsle_pkg::ST_IDLE;
          end
        end
      end

      // Single result of the command.
      bsle_pkg::ST_RESP: begin
        if (rq_free != '0) begin
          rq_push    = 1'b1;
          state_next = bsle_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bsle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bounded_sequence_list_engine_unit.sv =====
// Bounded sequence list engine: ordered list of signed words with positional
// insert, delete, locate, reverse and dump. Used as a queue on both sides.
// Requests enter when push is high and full is low, carrying command,
// position and item_value. Results leave in order: while empty is low the
// oldest result sits on status, result_value, found_position, element_count
// and last, and pop takes it. Each command gives one result; a dump of a
// non-empty list gives one result per element, last set on the final one.
// Requests wait in a two-entry queue and results in a four-entry queue, so
// both sides run independently. Commands execute one at a time, walking the
// element memory, which has one read and one write port: insert and delete
// shift the tail one entry at a time, locate scans from the front, reverse
// swaps pairs from both ends inward, and dump streams every element while
// the result queue has room. Reset empties the list and both queues; the
// element memory is not cleared, since only entries below the count are ever
// read. When the receiver stops popping, the result queue fills, the engine
// holds, and full rises once the request queue is full.
// Depends on bsle_pkg, bsle_front, bsle_back and bsle_rq.
module bounded_sequence_list_engine_unit #(
  parameter int CAPACITY   = bsle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bsle_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [bsle_pkg::CMD_W-1:0]           command,
  input  logic [bsle_pkg::POS_W-1:0]           position,
  input  logic signed [bsle_pkg::VAL_W-1:0]    item_value,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bsle_pkg::STAT_W-1:0]          status,
  output logic signed [bsle_pkg::VAL_W-1:0]    result_value,
  output logic [bsle_pkg::POS_W-1:0]           found_position,
  output logic [bsle_pkg::COUNT_W-1:0]         element_count,
  output logic                                 last
);

  bsle_pkg::cmd_t             cmd;
  logic                       cmd_valid;
  logic                       cmd_pop;
  logic [bsle_pkg::RQ_AW:0]   rq_free;
  logic                       rq_push;
  bsle_pkg::res_t             rq_data;
  bsle_pkg::res_t             head;

  // Request intake and classification.
  bsle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .position   (position),
    .item_value (item_value),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop)
  );

  // List storage and command execution.
  bsle_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rq_free   (rq_free),
    .rq_push   (rq_push),
    .rq_data   (rq_data)
  );

  // Result buffering toward the receiver.
  bsle_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (rq_push),
    .push_data (rq_data),
    .free      (rq_free),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign status         = head.status;
  assign result_value   = head.result_value;
  assign found_position = head.found_position;
  assign element_count  = head.element_count;
  assign last           = head.last;

endmodule
